[sv/gslt_pkg.sv]
package gslt_pkg;

    localparam int SLOT_DEPTH = 64;
    localparam int ROOT_DEPTH = 16;

    localparam logic [2:0] MODE_ALLOC    = 3'd0;
    localparam logic [2:0] MODE_RESOLVE  = 3'd1;
    localparam logic [2:0] MODE_MARK     = 3'd2;
    localparam logic [2:0] MODE_RECLAIM  = 3'd3;
    localparam logic [2:0] MODE_SCAN     = 3'd4;
    localparam logic [2:0] MODE_ROOT_ADD = 3'd5;
    localparam logic [2:0] MODE_ROOT_DEL = 3'd6;

    localparam logic [2:0] STS_OK         = 3'd0;
    localparam logic [2:0] STS_STALE      = 3'd1;
    localparam logic [2:0] STS_PENDING    = 3'd2;
    localparam logic [2:0] STS_ROOTS_FULL = 3'd3;
    localparam logic [2:0] STS_NO_VACANT  = 3'd4;

    localparam logic [1:0] SS_VACANT  = 2'd0;
    localparam logic [1:0] SS_LIVE    = 2'd1;
    localparam logic [1:0] SS_PENDING = 2'd2;
    localparam logic [1:0] SS_RETIRED = 2'd3;

    localparam logic [1:0] CFG_SLOTS     = 2'd0;
    localparam logic [1:0] CFG_ROOTS     = 2'd1;
    localparam logic [1:0] CFG_SLOT_SIZE = 2'd2;

    localparam logic [21:0] SUM_MAX = 22'h3FFFFF;
    localparam logic [15:0] GEN_TOP = 16'hFFFF;

    typedef enum logic [2:0] {
        ADDR_HOLD,
        ADDR_ZERO,
        ADDR_HIDX,
        ADDR_NEXT,
        ADDR_CURSOR
    } t_addr_sel;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_RESOLVE,
        OP_ALLOC,
        OP_MARK,
        OP_DESTROY,
        OP_ROOT_ADD,
        OP_ROOT_DEL
    } t_op;

    typedef struct packed {
        logic       capture;
        t_addr_sel  addr_sel;
        t_op        op;
        logic       set_st;
        logic [2:0] st_code;
        logic       mul;
        logic       fin;
    } t_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic       n_zero;
        logic       hnd_ok;
        logic       slot_free;
        logic       slot_live;
        logic       slot_pend;
        logic       gen_eq;
        logic       addr_last;
        logic       scan_go;
    } t_stat;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  result_index;
        logic [15:0] result_generation;
        logic [6:0]  slots_visited;
        logic [6:0]  objects_destroyed;
        logic [6:0]  pending_count;
        logic [6:0]  occupied_count;
        logic [6:0]  retired_count;
        logic [4:0]  root_count;
        logic [21:0] payload_total;
        logic [21:0] fragmentation_bytes;
    } t_result;

endpackage

[sv/gslt_in_if.sv]
interface gslt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [5:0]  handle_index;
    logic [15:0] handle_generation;
    logic [15:0] object_bytes;
    logic [6:0]  scan_budget;

    modport source(
        output valid, mode, handle_index, handle_generation, object_bytes, scan_budget,
        input  ready
    );
    modport sink(
        input  valid, mode, handle_index, handle_generation, object_bytes, scan_budget,
        output ready
    );
endinterface

[sv/gslt_out_if.sv]
interface gslt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [5:0]  result_index;
    logic [15:0] result_generation;
    logic [6:0]  slots_visited;
    logic [6:0]  objects_destroyed;
    logic [6:0]  pending_count;
    logic [6:0]  occupied_count;
    logic [6:0]  retired_count;
    logic [4:0]  root_count;
    logic [21:0] payload_total;
    logic [21:0] fragmentation_bytes;

    modport source(
        output valid, status, result_index, result_generation, slots_visited,
               objects_destroyed, pending_count, occupied_count, retired_count,
               root_count, payload_total, fragmentation_bytes,
        input  ready
    );
    modport sink(
        input  valid, status, result_index, result_generation, slots_visited,
               objects_destroyed, pending_count, occupied_count, retired_count,
               root_count, payload_total, fragmentation_bytes,
        output ready
    );
endinterface

[sv/generational_slot_table.sv]
// One item is in flight at a time; the next input is taken in the cycle after the result.
// Resolve, mark, reclaim and add root with a well-formed handle read the handle's slot;
// remove root, an unused mode, a rejected handle or an empty table read no slot; an
// allocation inspects slots from index zero upwards until one is free, and a scan
// visits slots from its cursor; the slot memory is read once per visit.
// Reset is synchronous and active low; per-slot valid bits make all slots read as vacant.
module generational_slot_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    gslt_in_if.sink     i_req,
    gslt_out_if.source  o_rsp
);
    import gslt_pkg::*;

    t_cmd    cmd;
    t_stat   stat;
    t_result res;

    gslt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .o_out_valid(o_rsp.valid),
        .i_out_ready(o_rsp.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gslt_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_mode             (i_req.mode),
        .i_handle_index     (i_req.handle_index),
        .i_handle_generation(i_req.handle_generation),
        .i_object_bytes     (i_req.object_bytes),
        .i_scan_budget      (i_req.scan_budget),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .o_result           (res)
    );

    assign o_rsp.status = res.status;
    assign o_rsp.result_index = res.result_index;
    assign o_rsp.result_generation = res.result_generation;
    assign o_rsp.slots_visited = res.slots_visited;
    assign o_rsp.objects_destroyed = res.objects_destroyed;
    assign o_rsp.pending_count = res.pending_count;
    assign o_rsp.occupied_count = res.occupied_count;
    assign o_rsp.retired_count = res.retired_count;
    assign o_rsp.root_count = res.root_count;
    assign o_rsp.payload_total = res.payload_total;
    assign o_rsp.fragmentation_bytes = res.fragmentation_bytes;
endmodule

[sv/gslt_ram.sv]
module gslt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [(DEPTH>1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [(DEPTH>1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[sv/gslt_datapath.sv]
module gslt_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    input  logic [2:0]        i_mode,
    input  logic [5:0]        i_handle_index,
    input  logic [15:0]       i_handle_generation,
    input  logic [15:0]       i_object_bytes,
    input  logic [6:0]        i_scan_budget,
    input  gslt_pkg::t_cmd    i_cmd,
    output gslt_pkg::t_stat   o_stat,
    output gslt_pkg::t_result o_result
);
    import gslt_pkg::*;

    localparam int AW = SLOT_DEPTH > 1 ? $clog2(SLOT_DEPTH) : 1;

    logic [6:0]  r_slots;
    logic [4:0]  r_roots;
    logic [15:0] r_ssize;

    logic [2:0]  r_mode;
    logic [5:0]  r_hidx;
    logic [15:0] r_hgen;
    logic [15:0] r_obytes;
    logic [6:0]  r_budget;

    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_cursor;
    logic          r_valid [SLOT_DEPTH];
    logic          r_vld_q;

    logic [6:0]  r_occ;
    logic [6:0]  r_pend;
    logic [6:0]  r_ret;
    logic [4:0]  r_act;
    logic [21:0] r_sum;

    logic [5:0]  r_rslot [ROOT_DEPTH];
    logic [15:0] r_rgen  [ROOT_DEPTH];

    logic [2:0]  r_status;
    logic [5:0]  r_ridx;
    logic [15:0] r_res_gen;
    logic [6:0]  r_visited;
    logic [6:0]  r_destroyed;
    logic [22:0] r_prod;
    logic [21:0] r_frag;

    logic [17:0]   slot_rd;
    logic [15:0]   pay_rd;
    logic          slot_we;
    logic [17:0]   slot_wd;
    logic [6:0]    n;
    logic [8:0]    rn;
    logic [1:0]    cur_st;
    logic [15:0]   cur_gen;
    logic [15:0]   alloc_gen;
    logic          can_adv;
    logic [AW-1:0] cur_fix;
    logic [6:0]    limit;
    logic [22:0]   sum_add;
    logic [22:0]   frag_diff;
    logic [ROOT_DEPTH-1:0] free_oh;
    logic [ROOT_DEPTH-1:0] del_oh;
    logic [ROOT_DEPTH-1:0] kill;
    logic          free_any;
    logic          del_any;
    logic [8:0]    kill_cnt;
    logic [4:0]    act_after_kill;

    gslt_ram #(.WIDTH(18), .DEPTH(SLOT_DEPTH)) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (slot_we),
        .i_waddr(r_addr),
        .i_wdata(slot_wd),
        .i_raddr(r_addr),
        .o_rdata(slot_rd)
    );

    gslt_ram #(.WIDTH(16), .DEPTH(SLOT_DEPTH)) u_pay_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.op == OP_ALLOC),
        .i_waddr(r_addr),
        .i_wdata(r_obytes),
        .i_raddr(r_addr),
        .o_rdata(pay_rd)
    );

    always_comb begin
        n = (13'(r_slots) > 13'(SLOT_DEPTH)) ? 7'(SLOT_DEPTH) : r_slots;
        rn = (9'(r_roots) > 9'(ROOT_DEPTH)) ? 9'(ROOT_DEPTH) : 9'(r_roots);
        cur_st = r_vld_q ? slot_rd[17:16] : SS_VACANT;
        cur_gen = r_vld_q ? slot_rd[15:0] : 16'd0;
        alloc_gen = (cur_gen == 16'd0) ? 16'd1 : cur_gen + 16'd1;
        can_adv = (cur_gen != GEN_TOP);
        cur_fix = (13'(r_cursor) >= 13'(n)) ? '0 : r_cursor;
        limit = (r_budget < n) ? r_budget : n;
        sum_add = {1'b0, r_sum} + 23'(r_obytes);
        frag_diff = r_prod - 23'(r_sum);
    end

    always_comb begin
        slot_we = 1'b0;
        slot_wd = {cur_st, cur_gen};
        case (i_cmd.op)
            OP_ALLOC: begin
                slot_we = 1'b1;
                slot_wd = {SS_LIVE, alloc_gen};
            end
            OP_MARK: begin
                slot_we = 1'b1;
                slot_wd = {SS_PENDING, cur_gen};
            end
            OP_DESTROY: begin
                slot_we = 1'b1;
                slot_wd = {can_adv ? SS_VACANT : SS_RETIRED, cur_gen};
            end
            default: begin
                slot_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        logic seen_free;
        logic seen_del;
        logic in_use;
        seen_free = 1'b0;
        seen_del = 1'b0;
        for (int i = 0; i < ROOT_DEPTH; i++) begin
            in_use = (9'(i) < rn);
            free_oh[i] = in_use && (r_rgen[i] == 16'd0) && !seen_free;
            del_oh[i] = in_use && (r_rgen[i] == r_hgen) && (r_rslot[i] == r_hidx) && !seen_del;
            kill[i] = in_use && (r_rgen[i] != 16'd0) && (r_rgen[i] == cur_gen)
                      && (r_rslot[i] == 6'(r_addr));
            seen_free = seen_free || free_oh[i];
            seen_del = seen_del || del_oh[i];
        end
        free_any = seen_free;
        del_any = seen_del && (r_hgen != 16'd0);
        kill_cnt = 9'($countones(kill));
        act_after_kill = (9'(r_act) > kill_cnt) ? 5'(9'(r_act) - kill_cnt) : 5'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ROOT_DEPTH; i++) begin
                r_rslot[i] <= '0;
                r_rgen[i] <= '0;
            end
        end else begin
            for (int i = 0; i < ROOT_DEPTH; i++) begin
                if ((i_cmd.op == OP_DESTROY && kill[i])
                    || (i_cmd.op == OP_ROOT_DEL && del_any && del_oh[i])) begin
                    r_rslot[i] <= '0;
                    r_rgen[i] <= '0;
                end else if (i_cmd.op == OP_ROOT_ADD && free_oh[i]) begin
                    r_rslot[i] <= r_hidx;
                    r_rgen[i] <= r_hgen;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_hidx <= i_handle_index;
            r_hgen <= i_handle_generation;
            r_obytes <= i_object_bytes;
            r_budget <= i_scan_budget;
        end
        if (i_cmd.mul) begin
            r_prod <= 23'(r_occ) * 23'(r_ssize);
        end
        if (i_cmd.fin) begin
            if (r_prod <= 23'(r_sum)) begin
                r_frag <= '0;
            end else if (frag_diff > 23'(SUM_MAX)) begin
                r_frag <= SUM_MAX;
            end else begin
                r_frag <= 22'(frag_diff);
            end
        end
        r_vld_q <= r_valid[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots <= 7'd64;
            r_roots <= 5'd16;
            r_ssize <= 16'd64;
            r_addr <= '0;
            r_cursor <= '0;
            for (int i = 0; i < SLOT_DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
            r_occ <= '0;
            r_pend <= '0;
            r_ret <= '0;
            r_act <= '0;
            r_sum <= '0;
            r_status <= STS_OK;
            r_ridx <= '0;
            r_res_gen <= '0;
            r_visited <= '0;
            r_destroyed <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SLOTS:     r_slots <= i_cfg_data[6:0];
                    CFG_ROOTS:     r_roots <= i_cfg_data[4:0];
                    CFG_SLOT_SIZE: r_ssize <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.capture) begin
                r_status <= STS_OK;
                r_ridx <= '0;
                r_res_gen <= '0;
                r_visited <= '0;
                r_destroyed <= '0;
            end
            if (i_cmd.set_st) begin
                r_status <= i_cmd.st_code;
            end
            unique case (i_cmd.addr_sel)
                ADDR_ZERO: r_addr <= '0;
                ADDR_HIDX: r_addr <= AW'(r_hidx);
                ADDR_NEXT: r_addr <= r_addr + AW'(1);
                ADDR_CURSOR: begin
                    r_addr <= cur_fix;
                    r_cursor <= (13'(cur_fix) + 13'd1 >= 13'(n)) ? '0 : cur_fix + AW'(1);
                    r_visited <= r_visited + 7'd1;
                end
                default: begin
                end
            endcase
            unique case (i_cmd.op)
                OP_RESOLVE: begin
                    r_ridx <= r_hidx;
                    r_res_gen <= r_hgen;
                end
                OP_ALLOC: begin
                    r_valid[r_addr] <= 1'b1;
                    r_occ <= r_occ + 7'd1;
                    r_sum <= (sum_add > 23'(SUM_MAX)) ? SUM_MAX : 22'(sum_add);
                    r_ridx <= 6'(r_addr);
                    r_res_gen <= alloc_gen;
                end
                OP_MARK: begin
                    r_pend <= r_pend + 7'd1;
                end
                OP_DESTROY: begin
                    r_act <= act_after_kill;
                    if (!can_adv) begin
                        r_ret <= r_ret + 7'd1;
                    end
                    if (r_occ != 7'd0) begin
                        r_occ <= r_occ - 7'd1;
                    end
                    if (cur_st == SS_PENDING && r_pend != 7'd0) begin
                        r_pend <= r_pend - 7'd1;
                    end
                    if (r_sum >= 22'(pay_rd)) begin
                        r_sum <= r_sum - 22'(pay_rd);
                    end
                    r_destroyed <= r_destroyed + 7'd1;
                end
                OP_ROOT_ADD: begin
                    if (free_any) begin
                        r_act <= r_act + 5'd1;
                    end else begin
                        r_status <= STS_ROOTS_FULL;
                    end
                end
                OP_ROOT_DEL: begin
                    if (del_any) begin
                        if (r_act != 5'd0) begin
                            r_act <= r_act - 5'd1;
                        end
                    end else begin
                        r_status <= STS_STALE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_stat.mode = r_mode;
        o_stat.n_zero = (n == 7'd0);
        o_stat.hnd_ok = (r_hgen != 16'd0) && (7'(r_hidx) < n);
        o_stat.slot_free = (cur_st == SS_VACANT) && can_adv;
        o_stat.slot_live = (cur_st == SS_LIVE);
        o_stat.slot_pend = (cur_st == SS_PENDING);
        o_stat.gen_eq = (cur_gen == r_hgen);
        o_stat.addr_last = (13'(r_addr) + 13'd1 >= 13'(n));
        o_stat.scan_go = (r_visited < limit) && (r_pend != 7'd0);

        o_result.status = r_status;
        o_result.result_index = r_ridx;
        o_result.result_generation = r_res_gen;
        o_result.slots_visited = r_visited;
        o_result.objects_destroyed = r_destroyed;
        o_result.pending_count = r_pend;
        o_result.occupied_count = r_occ;
        o_result.retired_count = r_ret;
        o_result.root_count = r_act;
        o_result.payload_total = r_sum;
        o_result.fragmentation_bytes = r_frag;
    end
endmodule

[sv/gslt_ctrl.sv]
module gslt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  gslt_pkg::t_stat i_stat,
    output gslt_pkg::t_cmd  o_cmd
);
    import gslt_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_DISP = 11'b000_0000_0010,
        S_ARD  = 11'b000_0000_0100,
        S_ACHK = 11'b000_0000_1000,
        S_HRD  = 11'b000_0001_0000,
        S_HCHK = 11'b000_0010_0000,
        S_STST = 11'b000_0100_0000,
        S_SRD  = 11'b000_1000_0000,
        S_SCHK = 11'b001_0000_0000,
        S_MUL  = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_fin;
    logic   match_any;
    logic   match_live;

    always_comb begin
        match_live = i_stat.slot_live && i_stat.gen_eq;
        match_any = (i_stat.slot_live || i_stat.slot_pend) && i_stat.gen_eq;
        n_state = r_state;
        o_cmd = '0;
        o_cmd.addr_sel = ADDR_HOLD;
        o_cmd.op = OP_NONE;
        o_cmd.st_code = STS_OK;
        o_in_ready = (r_state == S_IDLE);
        o_out_valid = (r_state == S_DONE) && !r_fin;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_MUL;
                case (i_stat.mode)
                    MODE_ALLOC: begin
                        if (i_stat.n_zero) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st_code = STS_NO_VACANT;
                        end else begin
                            o_cmd.addr_sel = ADDR_ZERO;
                            n_state = S_ARD;
                        end
                    end
                    MODE_RESOLVE, MODE_MARK, MODE_RECLAIM, MODE_ROOT_ADD: begin
                        if (i_stat.hnd_ok) begin
                            o_cmd.addr_sel = ADDR_HIDX;
                            n_state = S_HRD;
                        end else begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st_code = STS_STALE;
                        end
                    end
                    MODE_SCAN: n_state = S_STST;
                    MODE_ROOT_DEL: o_cmd.op = OP_ROOT_DEL;
                    default: begin
                        o_cmd.set_st = 1'b1;
                        o_cmd.st_code = STS_STALE;
                    end
                endcase
            end
            S_ARD: n_state = S_ACHK;
            S_ACHK: begin
                if (i_stat.slot_free) begin
                    o_cmd.op = OP_ALLOC;
                    n_state = S_MUL;
                end else if (i_stat.addr_last) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st_code = STS_NO_VACANT;
                    n_state = S_MUL;
                end else begin
                    o_cmd.addr_sel = ADDR_NEXT;
                    n_state = S_ARD;
                end
            end
            S_HRD: n_state = S_HCHK;
            S_HCHK: begin
                n_state = S_MUL;
                if (i_stat.mode == MODE_RESOLVE) begin
                    if (match_live) begin
                        o_cmd.op = OP_RESOLVE;
                    end else begin
                        o_cmd.set_st = 1'b1;
                        o_cmd.st_code = STS_STALE;
                    end
                end else if (!match_any) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st_code = STS_STALE;
                end else if (i_stat.mode == MODE_RECLAIM) begin
                    o_cmd.op = OP_DESTROY;
                end else if (i_stat.slot_pend) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st_code = STS_PENDING;
                end else if (i_stat.mode == MODE_MARK) begin
                    o_cmd.op = OP_MARK;
                end else begin
                    o_cmd.op = OP_ROOT_ADD;
                end
            end
            S_STST: begin
                if (i_stat.scan_go) begin
                    o_cmd.addr_sel = ADDR_CURSOR;
                    n_state = S_SRD;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_SRD: n_state = S_SCHK;
            S_SCHK: begin
                if (i_stat.slot_pend) begin
                    o_cmd.op = OP_DESTROY;
                end
                n_state = S_STST;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_cmd.fin = r_fin;
                if (!r_fin && i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fin <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fin <= (n_state == S_DONE) && (r_state != S_DONE);
        end
    end
endmodule
